// ----- sv/priority_ready_queue_scheduler_defines.svh -----
// Assertion macros shared by the scheduler modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Property that must hold at every clock edge outside of reset.
`define PRQS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define PRQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/prqs_pkg.sv -----
// Package for the priority ready queue scheduler: request and status codes,
// field widths, reset constants and the controller command type. No dependencies.
package prqs_pkg;

	// Field widths fixed by the interface.
	localparam int ID_W    = 6;
	localparam int PRIO_W  = 6;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;
	localparam int SLICE_W = 8;

	// Default queue depth and the priority ceiling.
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam logic [SLICE_W-1:0] MAX_PRIORITY = 8'd63;

	// Slice length after reset and the saturation point of the tick counter.
	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;
	localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'd255;

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_PICK   = 2'd1,
		REQ_TICK   = 2'd2
	} req_t;

	// Status codes.
	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_req;
		logic execute;
	} cmd_t;

endpackage

// ----- sv/prqs_ctrl.sv -----
// Controller of the priority ready queue scheduler: request sequencing and
// the result valid flag. Depends on prqs_pkg and the assertion macro header.
`include "priority_ready_queue_scheduler_defines.svh"

module prqs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output prqs_pkg::cmd_t cmd
);

	prqs_pkg::state_t state_q;
	prqs_pkg::state_t state_d;
	logic             out_valid_q;

	// Next state: a request is captured in idle and executed once the
	// result register is free.
	always_comb begin
		state_d = state_q;
		case (state_q)
			prqs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = prqs_pkg::ST_EXEC;
				end
			end
			prqs_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = prqs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prqs_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready      = 1'b0;
		cmd.latch_req = 1'b0;
		cmd.execute   = 1'b0;
		case (state_q)
			prqs_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.latch_req = in_valid;
			end
			prqs_pkg::ST_EXEC: begin
				cmd.execute = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prqs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`PRQS_ASSERT_NEXT(a_accept_goes_exec, in_valid && in_ready, state_q == prqs_pkg::ST_EXEC,
		"accepted request did not enter execution")
	`PRQS_ASSERT_NEXT(a_stall_holds_exec,
		state_q == prqs_pkg::ST_EXEC && out_valid_q && !out_ready,
		state_q == prqs_pkg::ST_EXEC, "request executed while the result register was full")
	`PRQS_ASSERT_NEXT(a_execute_sets_valid, cmd.execute, out_valid_q,
		"executed request produced no result")
	`PRQS_ASSERT(a_no_exec_in_idle, !(cmd.execute && state_q == prqs_pkg::ST_IDLE),
		"execute issued while idle")

endmodule

// ----- sv/prqs_dp.sv -----
// Datapath of the priority ready queue scheduler: the sorted shift-register
// queue, the slice counter, the slice length register and the result register.
// Depends on prqs_pkg and the assertion macro header.
`include "priority_ready_queue_scheduler_defines.svh"

module prqs_dp #(
	parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  prqs_pkg::cmd_t               cmd,
	input  logic [prqs_pkg::REQ_W-1:0]   req_type,
	input  logic [prqs_pkg::ID_W-1:0]    thread_id,
	input  logic [prqs_pkg::PRIO_W-1:0]  priority_req,
	input  logic                         cfg_we,
	input  logic [prqs_pkg::SLICE_W-1:0] cfg_data,
	output logic [prqs_pkg::ID_W-1:0]    chosen_id,
	output logic [prqs_pkg::STAT_W-1:0]  status,
	output logic                         preempt
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Captured request; the priority is saturated on capture.
	prqs_pkg::req_t               req_q;
	logic [prqs_pkg::ID_W-1:0]    id_q;
	logic [prqs_pkg::PRIO_W-1:0]  prio_q;
	logic [prqs_pkg::PRIO_W-1:0]  prio_sat;

	// Queue cells, front at index 0.
	logic [prqs_pkg::ID_W-1:0]    ids_q   [QUEUE_DEPTH];
	logic [prqs_pkg::PRIO_W-1:0]  prios_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]             count_q;
	logic [QUEUE_DEPTH-1:0]       keep;

	logic [prqs_pkg::SLICE_W-1:0] slice_count_q;
	logic [prqs_pkg::SLICE_W-1:0] slice_length_q;
	logic [prqs_pkg::SLICE_W-1:0] slice_next;

	logic                         q_full;
	logic                         q_empty;
	logic                         do_insert;
	logic                         do_pop;

	logic [prqs_pkg::ID_W-1:0]    chosen_q;
	logic [prqs_pkg::STAT_W-1:0]  status_q;
	logic                         preempt_q;

	// Priority saturation at the ceiling.
	always_comb begin
		if ({{(prqs_pkg::SLICE_W - prqs_pkg::PRIO_W){1'b0}}, priority_req}
				> prqs_pkg::MAX_PRIORITY) begin
			prio_sat = prqs_pkg::MAX_PRIORITY[prqs_pkg::PRIO_W-1:0];
		end else begin
			prio_sat = priority_req;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q  <= prqs_pkg::req_t'(req_type);
			id_q   <= thread_id;
			prio_q <= prio_sat;
		end
	end

	assign q_full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty   = (count_q == '0);
	assign do_insert = cmd.execute && (req_q == prqs_pkg::REQ_INSERT) && !q_full;
	assign do_pop    = cmd.execute && (req_q == prqs_pkg::REQ_PICK) && !q_empty;

	// Each cell holds its entry when it is valid and at least as urgent as
	// the new one; the sorted order makes these flags a thermometer code.
	generate
		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			assign keep[i] = (CNT_W'(i) < count_q) && (prios_q[i] >= prio_q);

			always_ff @(posedge clk) begin
				if (do_insert) begin
					if (!keep[i]) begin
						if (i == 0) begin
							ids_q[i]   <= id_q;
							prios_q[i] <= prio_q;
						end else if (keep[(i == 0) ? 0 : i - 1]) begin
							ids_q[i]   <= id_q;
							prios_q[i] <= prio_q;
						end else begin
							ids_q[i]   <= ids_q[(i == 0) ? 0 : i - 1];
							prios_q[i] <= prios_q[(i == 0) ? 0 : i - 1];
						end
					end
				end else if (do_pop) begin
					if (i < QUEUE_DEPTH - 1) begin
						ids_q[i]   <= ids_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
						prios_q[i] <= prios_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
					end
				end
			end
		end
	endgenerate

	// Saturating tick count.
	assign slice_next = (slice_count_q == prqs_pkg::SLICE_MAX) ? slice_count_q
		: slice_count_q + prqs_pkg::SLICE_W'(1);

	// Control state: entry count, slice counter and slice length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			slice_count_q  <= '0;
			slice_length_q <= prqs_pkg::SLICE_RESET;
		end else begin
			if (cfg_we) begin
				slice_length_q <= cfg_data;
			end
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.execute) begin
				case (req_q)
					prqs_pkg::REQ_PICK: slice_count_q <= '0;
					prqs_pkg::REQ_TICK: slice_count_q <= slice_next;
					default:            slice_count_q <= slice_count_q;
				endcase
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			chosen_q  <= '0;
			status_q  <= prqs_pkg::STATUS_OK;
			preempt_q <= 1'b0;
			case (req_q)
				prqs_pkg::REQ_INSERT: begin
					if (q_full) begin
						status_q <= prqs_pkg::STATUS_FULL;
					end
				end
				prqs_pkg::REQ_PICK: begin
					if (q_empty) begin
						status_q <= prqs_pkg::STATUS_EMPTY;
					end else begin
						chosen_q <= ids_q[0];
					end
				end
				prqs_pkg::REQ_TICK: begin
					preempt_q <= (slice_next >= slice_length_q);
				end
				default: begin
					status_q <= prqs_pkg::STATUS_OK;
				end
			endcase
		end
	end

	assign chosen_id = chosen_q;
	assign status    = status_q;
	assign preempt   = preempt_q;

	`PRQS_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH),
		"queue count exceeds the depth")
	`PRQS_ASSERT_NEXT(a_insert_grows, do_insert, count_q == $past(count_q) + CNT_W'(1),
		"insert did not grow the queue by one")
	`PRQS_ASSERT_NEXT(a_pop_shrinks, do_pop, count_q == $past(count_q) - CNT_W'(1),
		"pick did not shrink the queue by one")

endmodule

// ----- sv/priority_ready_queue_scheduler.sv -----
// Priority ready queue scheduler, top level: controller, datapath and the
// configuration port. Depends on prqs_pkg, prqs_ctrl and prqs_dp.
//
// Usage:
//   The request channel (in_valid/in_ready) carries req_type, thread_id and
//   priority_req: insert a thread at its priority, pick the front thread, or
//   count a timer tick. Every request yields exactly one result transaction on
//   the result channel (out_valid/out_ready) with chosen_id, status, preempt.
//   The queue holds up to QUEUE_DEPTH entries, highest priority first and first
//   in, first out among equal priorities; it is a row of shift-register cells
//   that shift to place or remove an entry.
//   The request is captured when it is accepted; the result register is loaded
//   when the request executes. A new request is accepted only after the last
//   one has executed; the controller steps through capture, then execute.
//   The result register decouples the two sides: a new request is accepted
//   while a finished result waits; if the receiver stalls, the next request
//   waits in execution until the result is taken.
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   slice length; write it only while the block is idle.
//   Reset: empty queue, slice count zero, slice length four; no clearing pass.
module priority_ready_queue_scheduler #(
	parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [prqs_pkg::REQ_W-1:0]   req_type,
	input  logic [prqs_pkg::ID_W-1:0]    thread_id,
	input  logic [prqs_pkg::PRIO_W-1:0]  priority_req,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [prqs_pkg::ID_W-1:0]    chosen_id,
	output logic [prqs_pkg::STAT_W-1:0]  status,
	output logic                         preempt,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [prqs_pkg::SLICE_W-1:0] cfg_data
);

	prqs_pkg::cmd_t cmd;

	// The slice length register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	prqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	prqs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req_type),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.cfg_we       (cfg_valid),
		.cfg_data     (cfg_data),
		.chosen_id    (chosen_id),
		.status       (status),
		.preempt      (preempt)
	);

endmodule
